[rtl/i2crts_pkg.sv]
// ----------------------------------------------------------------------------
// i2crts_pkg - shared types and constants of the i2c register sequencer
// beat layouts, action and event codes, ring geometry and slot arithmetic
// ----------------------------------------------------------------------------
package i2crts_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [7:0] RETRY_MAX       = 8'hFF;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_START     = 3'd1,
        ACT_SEND      = 3'd2,
        ACT_RESTART   = 3'd3,
        ACT_STOP      = 3'd4,
        ACT_NACK_WAIT = 3'd5,
        ACT_STOP_DATA = 3'd6,
        ACT_REINIT    = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        EV_START    = 3'd0,
        EV_TX_EMPTY = 3'd1,
        EV_TX_END   = 3'd2,
        EV_RX_FULL  = 3'd3,
        EV_STOP     = 3'd4,
        EV_NACK     = 3'd5,
        EV_ARB_LOST = 3'd6,
        EV_TIMEOUT  = 3'd7
    } t_event;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_EVENT   = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [2:0] event_kind;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic       read_request;
        logic [7:0] write_byte;
        logic       bus_busy;
        logic [7:0] received_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] transmit_byte;
        logic [7:0] read_result;
        logic [3:0] result_slot;
        logic       queue_full;
        logic       queue_empty;
        logic [7:0] busy_retries;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] dev;
        logic [7:0] regaddr;
        logic       rd;
        logic [7:0] data;
    } t_req_entry;

    function automatic t_slot next_slot(t_slot s);
        return (s == t_slot'(QUEUE_DEPTH - 1)) ? '0 : t_slot'(s + 1'b1);
    endfunction

endpackage

[rtl/i2c_register_transfer_sequencer.sv]
// latency: a beat accepted at one edge gives its result strobe in the next cycle
// throughput: one beat per cycle, busy stays low, state updates in a single pass
// the request ring is a flip-flop array read at the head slot in the same cycle
// results are strobed for one cycle only, the receiver cannot stall
// reset (synchronous, active low): idle, slots zero, queue empty, retries zero
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer - i2c master register read/write sequencer
// queues single-byte register transfers and steps them through bus events
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  i2crts_pkg::t_in_beat  i_item,
    output logic                  o_strobe,
    output i2crts_pkg::t_out_beat o_result
);

    typedef enum logic [3:0] {
        S_IDLE          = 4'd0,
        S_START_SENT    = 4'd1,
        S_SLAW_SET      = 4'd2,
        S_RADDR_SET     = 4'd3,
        S_WADDR_SET     = 4'd4,
        S_DATA_SET      = 4'd5,
        S_RADDR_SENT    = 4'd6,
        S_RESTART_SENT  = 4'd7,
        S_SLAR_SET      = 4'd8,
        S_DUMMY_READ    = 4'd9,
        S_DATA_RECEIVED = 4'd10
    } t_seq_state;

    t_seq_state            r_state, n_state;
    i2crts_pkg::t_slot     r_head, n_head;
    i2crts_pkg::t_slot     r_tail, n_tail;
    logic                  r_empty, n_empty;
    logic [7:0]            r_count, n_count;
    logic                  r_strobe;
    i2crts_pkg::t_out_beat r_result, n_result;
    logic                  n_write;

    i2crts_pkg::t_req_entry r_ring [i2crts_pkg::QUEUE_DEPTH];
    i2crts_pkg::t_req_entry cur;
    i2crts_pkg::t_req_entry w_entry;
    i2crts_pkg::t_slot      head_next;
    i2crts_pkg::t_action    act;
    logic [7:0]             txb;
    logic [7:0]             rdv;
    logic                   full;
    logic                   accept;
    logic                   try_start;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cur    = r_ring[r_head];
    assign head_next = i2crts_pkg::next_slot(r_head);

    assign w_entry = '{dev: i_item.device_address, regaddr: i_item.register_address,
                       rd: i_item.read_request, data: i_item.write_byte};

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_count   = r_count;
        n_write   = 1'b0;
        act       = i2crts_pkg::ACT_NONE;
        txb       = 8'h00;
        rdv       = 8'h00;
        full      = 1'b0;
        try_start = 1'b0;

        if (i_item.operation == i2crts_pkg::OP_ENQUEUE) begin
            if (i2crts_pkg::next_slot(r_tail) == r_head) begin
                full = 1'b1;
            end else begin
                n_write   = 1'b1;
                n_tail    = i2crts_pkg::next_slot(r_tail);
                n_empty   = 1'b0;
                try_start = 1'b1;
            end
        end else begin
            unique case (i2crts_pkg::t_event'(i_item.event_kind))
                i2crts_pkg::EV_START: begin
                    if (r_state == S_IDLE) begin
                        n_state = S_START_SENT;
                    end else if (r_state == S_RADDR_SENT) begin
                        n_state = S_RESTART_SENT;
                    end
                end
                i2crts_pkg::EV_TX_EMPTY: begin
                    if (r_state == S_START_SENT) begin
                        n_state = S_SLAW_SET;
                        act     = i2crts_pkg::ACT_SEND;
                        txb     = cur.dev & i2crts_pkg::ADDR_WRITE_MASK;
                    end else if (r_state == S_SLAW_SET) begin
                        act     = i2crts_pkg::ACT_SEND;
                        txb     = cur.regaddr;
                        n_state = cur.rd ? S_RADDR_SET : S_WADDR_SET;
                    end else if (r_state == S_RESTART_SENT) begin
                        n_state = S_SLAR_SET;
                        act     = i2crts_pkg::ACT_SEND;
                        txb     = cur.dev | {7'b0, cur.rd};
                    end else if (r_state == S_WADDR_SET) begin
                        n_state = S_DATA_SET;
                        act     = i2crts_pkg::ACT_SEND;
                        txb     = cur.data;
                    end
                end
                i2crts_pkg::EV_TX_END: begin
                    if (r_state == S_RADDR_SET) begin
                        n_state = S_RADDR_SENT;
                        act     = i2crts_pkg::ACT_RESTART;
                    end else if (r_state == S_DATA_SET) begin
                        act     = i2crts_pkg::ACT_STOP;
                    end
                end
                i2crts_pkg::EV_RX_FULL: begin
                    if (r_state == S_SLAR_SET) begin
                        n_state = S_DUMMY_READ;
                        act     = i2crts_pkg::ACT_NACK_WAIT;
                    end else if (r_state == S_DUMMY_READ) begin
                        n_state = S_DATA_RECEIVED;
                        act     = i2crts_pkg::ACT_STOP_DATA;
                        rdv     = i_item.received_byte;
                    end
                end
                i2crts_pkg::EV_STOP: begin
                    n_state = S_IDLE;
                    if (!r_empty) begin
                        n_head = head_next;
                        if (r_tail != head_next) begin
                            try_start = 1'b1;
                        end else begin
                            n_empty = 1'b1;
                        end
                    end
                end
                i2crts_pkg::EV_NACK: begin
                    n_state = S_IDLE;
                    act     = i2crts_pkg::ACT_STOP;
                end
                i2crts_pkg::EV_ARB_LOST: begin
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                    act     = i2crts_pkg::ACT_REINIT;
                end
            endcase
        end

        if (try_start) begin
            if (!i_item.bus_busy) begin
                n_count = 8'h00;
                act     = i2crts_pkg::ACT_START;
            end else if (r_count != i2crts_pkg::RETRY_MAX) begin
                n_count = r_count + 8'd1;
            end
        end

        n_result.bus_action    = act;
        n_result.transmit_byte = txb;
        n_result.read_result   = rdv;
        n_result.result_slot   = 4'(n_head);
        n_result.queue_full    = full;
        n_result.queue_empty   = n_empty;
        n_result.busy_retries  = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_count  <= 8'h00;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_state  <= n_state;
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_empty  <= n_empty;
                r_count  <= n_count;
            end
        end
        if (accept) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_write) begin
            r_ring[r_tail] <= w_entry;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // every accepted beat gives one result in the next cycle
    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("accepted beat gave no result");

    a_no_result_without_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result without accepted beat");

    a_full_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.queue_full |-> o_result.bus_action == i2crts_pkg::ACT_NONE)
        else $error("refused enqueue issued a bus action");

    a_reinit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.bus_action == i2crts_pkg::ACT_REINIT
            |-> o_result.queue_empty && o_result.result_slot == 4'd0)
        else $error("reinit left queue state behind");

    a_tx_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.bus_action != i2crts_pkg::ACT_SEND
            |-> o_result.transmit_byte == 8'h00)
        else $error("transmit byte set without send action");

endmodule

[dv/i2c_register_transfer_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer_tb - self-checking bench of the i2c sequencer
// drives request and bus event beats, predicts every result beat in step with
// acceptance and checks the strobed results field by field in arrival order
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer_tb;
    import i2crts_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RUN_BEATS   = 520;
    localparam int CALM_FROM   = 460;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_SENT,
        PH_ADDR_W_SENT,
        PH_REG_RD_SENT,
        PH_REG_WR_SENT,
        PH_DATA_SENT,
        PH_REG_RD_DONE,
        PH_RESTARTED,
        PH_ADDR_R_SENT,
        PH_DUMMY_READ,
        PH_DATA_IN
    } t_seq_phase;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_beat  i_item;
    logic      o_strobe;
    t_out_beat o_result;

    // predicted block state
    t_req_entry request_ring [QUEUE_DEPTH];
    logic       entry_written [QUEUE_DEPTH];
    t_seq_phase seq_phase;
    t_slot      head_slot;
    t_slot      tail_slot;
    logic       queue_drained;
    logic [7:0] retry_count;

    t_out_beat expected_responses [$];
    int        mismatch_count  = 0;
    int        results_checked = 0;
    int        beats_sent      = 0;
    int        reads_returned  = 0;
    int        refused_count   = 0;
    int        retry_peak      = 0;
    int        stall_cycles    = 0;
    logic      gaps_on         = 1'b1;

    i2c_register_transfer_sequencer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_slot slot_after(t_slot s);
        return t_slot'((int'(s) + 1) % QUEUE_DEPTH);
    endfunction

    function automatic t_action attempt_start(logic bus_busy);
        if (!bus_busy) begin
            retry_count = '0;
            return ACT_START;
        end
        if (retry_count != RETRY_MAX) retry_count = retry_count + 8'd1;
        return ACT_NONE;
    endfunction

    function automatic t_out_beat predict_response(t_in_beat b);
        t_out_beat  r;
        t_req_entry cur;
        r   = '0;
        cur = request_ring[head_slot];
        if (b.operation == OP_ENQUEUE) begin
            if (slot_after(tail_slot) == head_slot) begin
                r.queue_full = 1'b1;
            end else begin
                request_ring[tail_slot].dev     = b.device_address;
                request_ring[tail_slot].regaddr = b.register_address;
                request_ring[tail_slot].rd      = b.read_request;
                request_ring[tail_slot].data    = b.write_byte;
                entry_written[tail_slot] = 1'b1;
                tail_slot     = slot_after(tail_slot);
                queue_drained = 1'b0;
                r.bus_action  = attempt_start(b.bus_busy);
            end
        end else begin
            case (t_event'(b.event_kind))
                EV_START: begin
                    if (seq_phase == PH_IDLE) seq_phase = PH_START_SENT;
                    else if (seq_phase == PH_REG_RD_DONE) seq_phase = PH_RESTARTED;
                end
                EV_TX_EMPTY: begin
                    case (seq_phase)
                        PH_START_SENT: begin
                            seq_phase       = PH_ADDR_W_SENT;
                            r.bus_action    = ACT_SEND;
                            r.transmit_byte = cur.dev & ADDR_WRITE_MASK;
                        end
                        PH_ADDR_W_SENT: begin
                            seq_phase       = cur.rd ? PH_REG_RD_SENT : PH_REG_WR_SENT;
                            r.bus_action    = ACT_SEND;
                            r.transmit_byte = cur.regaddr;
                        end
                        PH_RESTARTED: begin
                            seq_phase       = PH_ADDR_R_SENT;
                            r.bus_action    = ACT_SEND;
                            r.transmit_byte = cur.dev | {7'd0, cur.rd};
                        end
                        PH_REG_WR_SENT: begin
                            seq_phase       = PH_DATA_SENT;
                            r.bus_action    = ACT_SEND;
                            r.transmit_byte = cur.data;
                        end
                        default: ;
                    endcase
                end
                EV_TX_END: begin
                    if (seq_phase == PH_REG_RD_SENT) begin
                        seq_phase    = PH_REG_RD_DONE;
                        r.bus_action = ACT_RESTART;
                    end else if (seq_phase == PH_DATA_SENT) begin
                        r.bus_action = ACT_STOP;
                    end
                end
                EV_RX_FULL: begin
                    if (seq_phase == PH_ADDR_R_SENT) begin
                        seq_phase    = PH_DUMMY_READ;
                        r.bus_action = ACT_NACK_WAIT;
                    end else if (seq_phase == PH_DUMMY_READ) begin
                        seq_phase     = PH_DATA_IN;
                        r.bus_action  = ACT_STOP_DATA;
                        r.read_result = b.received_byte;
                    end
                end
                EV_STOP: begin
                    seq_phase = PH_IDLE;
                    if (!queue_drained) begin
                        head_slot = slot_after(head_slot);
                        if (tail_slot != head_slot) r.bus_action = attempt_start(b.bus_busy);
                        else queue_drained = 1'b1;
                    end
                end
                EV_NACK: begin
                    seq_phase    = PH_IDLE;
                    r.bus_action = ACT_STOP;
                end
                EV_ARB_LOST: begin
                    seq_phase = PH_IDLE;
                end
                default: begin
                    seq_phase     = PH_IDLE;
                    head_slot     = '0;
                    tail_slot     = '0;
                    queue_drained = 1'b1;
                    r.bus_action  = ACT_REINIT;
                end
            endcase
        end
        r.result_slot  = 4'(head_slot);
        r.queue_empty  = queue_drained;
        r.busy_retries = retry_count;
        return r;
    endfunction

    function automatic t_in_beat random_beat();
        t_in_beat b;
        b.operation        = 1'($urandom_range(0, 1));
        b.event_kind       = 3'($urandom_range(0, 7));
        b.device_address   = 8'($urandom);
        b.register_address = 8'($urandom);
        b.read_request     = 1'($urandom_range(0, 1));
        b.write_byte       = 8'($urandom);
        b.bus_busy         = 1'($urandom_range(0, 1));
        b.received_byte    = 8'($urandom);
        return b;
    endfunction

    function automatic t_in_beat make_event(t_event ev);
        t_in_beat b;
        b            = random_beat();
        b.operation  = OP_EVENT;
        b.event_kind = ev;
        b.bus_busy   = ($urandom_range(0, 3) == 0);
        return b;
    endfunction

    function automatic t_in_beat make_request(logic [7:0] dev, logic [7:0] regaddr,
                                              logic rd, logic [7:0] data, logic bus_busy);
        t_in_beat b;
        b                  = random_beat();
        b.operation        = OP_ENQUEUE;
        b.device_address   = dev;
        b.register_address = regaddr;
        b.read_request     = rd;
        b.write_byte       = data;
        b.bus_busy         = bus_busy;
        return b;
    endfunction

    task automatic issue_beat(input t_in_beat beat);
        t_out_beat want;
        int        gap;
        // a transmit-empty that would fetch a never-written head entry is swapped out
        if (beat.operation == OP_EVENT && beat.event_kind == EV_TX_EMPTY &&
            !entry_written[head_slot] &&
            (seq_phase == PH_START_SENT || seq_phase == PH_ADDR_W_SENT ||
             seq_phase == PH_RESTARTED || seq_phase == PH_REG_WR_SENT)) begin
            beat.event_kind = EV_ARB_LOST;
        end
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = predict_response(beat);
        expected_responses.push_back(want);
        beats_sent++;
        if (want.queue_full) refused_count++;
        if (want.bus_action == ACT_STOP_DATA) reads_returned++;
        if (int'(retry_count) > retry_peak) retry_peak = int'(retry_count);
    endtask

    task automatic send_event(t_event ev);
        issue_beat(make_event(ev));
    endtask

    task automatic test_write_transfer();
        issue_beat(make_request(8'hFF, 8'h00, 1'b0, 8'hFF, 1'b0));
        send_event(EV_START);
        send_event(EV_TX_EMPTY);
        send_event(EV_TX_EMPTY);
        send_event(EV_TX_EMPTY);
        send_event(EV_TX_END);
        send_event(EV_STOP);
    endtask

    task automatic test_read_transfer();
        t_in_beat b;
        issue_beat(make_request(8'h01, 8'hFF, 1'b1, 8'h00, 1'b1));
        send_event(EV_START);
        send_event(EV_TX_EMPTY);
        send_event(EV_TX_EMPTY);
        send_event(EV_TX_END);
        send_event(EV_START);
        send_event(EV_TX_EMPTY);
        b = make_event(EV_RX_FULL);
        b.received_byte = 8'h00;
        issue_beat(b);
        b = make_event(EV_RX_FULL);
        b.received_byte = 8'hFF;
        issue_beat(b);
        send_event(EV_STOP);
    endtask

    task automatic test_stray_events();
        send_event(EV_TX_END);
        send_event(EV_STOP);
        send_event(EV_START);
        send_event(EV_START);
        send_event(EV_ARB_LOST);
    endtask

    task automatic test_nack_and_timeout();
        issue_beat(make_request(8'($urandom), 8'($urandom), 1'b0, 8'($urandom), 1'b0));
        send_event(EV_START);
        send_event(EV_TX_EMPTY);
        send_event(EV_NACK);
        send_event(EV_STOP);
        issue_beat(make_request(8'($urandom), 8'($urandom), 1'b1, 8'($urandom), 1'b0));
        send_event(EV_TIMEOUT);
    endtask

    // fill the ring on a busy bus, bump into the full ring, drain, until retries saturate
    task automatic test_retry_saturation();
        t_in_beat b;
        while (retry_count != RETRY_MAX) begin
            while (slot_after(tail_slot) != head_slot) begin
                issue_beat(make_request(8'($urandom), 8'($urandom), 1'($urandom),
                                        8'($urandom), 1'b1));
            end
            issue_beat(make_request(8'($urandom), 8'($urandom), 1'($urandom),
                                    8'($urandom), 1'($urandom)));
            while (!queue_drained) begin
                b = make_event(EV_STOP);
                b.bus_busy = 1'b1;
                issue_beat(b);
            end
        end
        issue_beat(make_request(8'($urandom), 8'($urandom), 1'($urandom),
                                8'($urandom), 1'b0));
        send_event(EV_TIMEOUT);
    endtask

    task automatic run_transfer();
        t_event steps [$];
        int     spoil;
        issue_beat(make_request(8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                                $urandom_range(0, 3) == 0));
        if (request_ring[head_slot].rd) begin
            steps = '{EV_START, EV_TX_EMPTY, EV_TX_EMPTY, EV_TX_END, EV_START,
                      EV_TX_EMPTY, EV_RX_FULL, EV_RX_FULL, EV_STOP};
        end else begin
            steps = '{EV_START, EV_TX_EMPTY, EV_TX_EMPTY, EV_TX_EMPTY, EV_TX_END, EV_STOP};
        end
        if ($urandom_range(0, 7) == 0) begin
            spoil = $urandom_range(0, steps.size() - 1);
            steps[spoil] = t_event'($urandom_range(0, 7));
        end
        foreach (steps[k]) send_event(steps[k]);
    endtask

    task automatic test_random_traffic();
        int burst;
        while (beats_sent < RUN_BEATS) begin
            if (beats_sent >= CALM_FROM) gaps_on = 1'b0;
            else if ($urandom_range(0, 11) == 0) gaps_on = ~gaps_on;
            if ($urandom_range(0, 9) < 2) begin
                burst = $urandom_range(1, 4);
                repeat (burst) issue_beat(random_beat());
            end else begin
                run_transfer();
            end
        end
    endtask

    // result beats cannot be held off, so each strobe is checked where it lands
    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_strobe) begin
            if (expected_responses.size() == 0) begin
                $error("result beat with no prediction outstanding");
                mismatch_count++;
            end else begin
                want = expected_responses.pop_front();
                results_checked++;
                compare_field("bus_action", 8'(want.bus_action), 8'(o_result.bus_action));
                compare_field("transmit_byte", want.transmit_byte, o_result.transmit_byte);
                compare_field("read_result", want.read_result, o_result.read_result);
                compare_field("result_slot", 8'(want.result_slot), 8'(o_result.result_slot));
                compare_field("queue_full", 8'(want.queue_full), 8'(o_result.queue_full));
                compare_field("queue_empty", 8'(want.queue_empty), 8'(o_result.queue_empty));
                compare_field("busy_retries", want.busy_retries, o_result.busy_retries);
            end
        end
    end

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        foreach (request_ring[k]) begin
            request_ring[k]  = '0;
            entry_written[k] = 1'b0;
        end
        seq_phase     = PH_IDLE;
        head_slot     = '0;
        tail_slot     = '0;
        queue_drained = 1'b1;
        retry_count   = '0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_write_transfer();
        test_read_transfer();
        test_stray_events();
        test_nack_and_timeout();
        test_retry_saturation();
        test_random_traffic();

        start <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d beats in, %0d results checked, %0d read bytes returned",
                 beats_sent, results_checked, reads_returned);
        $display("ring refused %0d enqueues, retry count peaked at %0d",
                 refused_count, retry_peak);
        if (mismatch_count == 0 && expected_responses.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[i2c_register_transfer_sequencer.f]
rtl/i2crts_pkg.sv
rtl/i2c_register_transfer_sequencer.sv
dv/i2c_register_transfer_sequencer_tb.sv
